>>> rtl/rtks_pkg.sv
package rtks_pkg;

  localparam int ScoreW = 16;
  localparam int AgeW   = 8;
  localparam int KeyW   = ScoreW + AgeW;
  localparam int SlotW  = 7;
  localparam int MaxSlots = 64;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // One scan step asks the store for an entry and flags the last read.
  typedef struct packed {
    logic         rd_en;
    logic         last_rd;
  } scan_ctl_t;

endpackage

>>> rtl/rtks_store.sv
module rtks_store
  import rtks_pkg::*;
#(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [KeyW-1:0]  wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [KeyW-1:0]  rd_data
);

  logic [KeyW-1:0] mem [Depth];
  logic [KeyW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/ranked_top_k_selector.sv
// Records (score, age) are written into a store of CAPACITY entries, one per
// cycle while busy is low. On the record marked last the block goes busy
// (unless the slot count, clamped to 64, is zero) and produces the ranking by
// repeated selection: for each emitted slot it scans every stored record
// through the key comparators, one record per cycle, keeping the best record
// that ranks below the previous winner. Each result appears for a single
// cycle with out_valid; the receiver cannot hold it off. Unfilled slots
// follow at one per cycle. Records beyond CAPACITY are dropped and reported
// through out_overflow on every result of that batch.
module ranked_top_k_selector
  import rtks_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ScoreW-1:0] in_score,
  input  logic [AgeW-1:0]   in_age,
  input  logic              in_last_record,
  input  logic              cfg_we,
  input  logic [SlotW-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [SlotW-1:0]  out_rank,
  output logic [SlotW-1:0]  out_record_index,
  output logic              out_filled,
  output logic              out_overflow,
  output logic              out_last_result
);

  localparam int AddrW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int CmpW  = (CntW > SlotW) ? CntW : SlotW;

  state_t state_r, state_nxt;

  logic [SlotW-1:0] slot_cfg_r;
  logic [CntW-1:0]  count_r;
  logic             ovf_r;
  logic [SlotW-1:0] slots_r;
  logic [SlotW-1:0] k_r;
  logic [CntW-1:0]  scan_r;
  logic [AddrW-1:0] rd_idx_r;
  logic             rd_ok_r;

  // Previous winner key and index bound the next search.
  logic [KeyW-1:0]  prev_key_r;
  logic [CntW-1:0]  prev_idx_r;
  logic             have_prev_r;
  logic [KeyW-1:0]  best_key_r;
  logic [CntW-1:0]  best_idx_r;
  logic             best_ok_r;

  logic             out_valid_r;
  logic [SlotW-1:0] out_rank_r;
  logic [SlotW-1:0] out_idx_r;
  logic             out_filled_r;
  logic             out_ovf_r;
  logic             out_last_r;

  logic             accept;
  logic             store_wr;
  logic [KeyW-1:0]  rd_data;
  scan_ctl_t        ctl;
  logic [CntW-1:0]  cand_idx;
  logic             below_prev;
  logic             above_best;
  logic [SlotW-1:0] slots_clamped;
  logic [CmpW-1:0]  k_ext;
  logic [CmpW-1:0]  cnt_ext;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign store_wr = accept && (count_r < CntW'(CAPACITY));

  // Slot and record counts are compared at a common width.
  assign k_ext   = CmpW'(k_r);
  assign cnt_ext = CmpW'(count_r);

  assign ctl.rd_en   = (state_r == ST_READ) ||
                       ((state_r == ST_SCAN) && (scan_r < count_r));
  assign ctl.last_rd = (scan_r == count_r);

  rtks_store #(.Depth(CAPACITY), .AddrW(AddrW)) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (count_r[AddrW-1:0]),
    .wr_data ({in_score, in_age}),
    .rd_en   (ctl.rd_en),
    .rd_addr (scan_r[AddrW-1:0]),
    .rd_data (rd_data)
  );

  assign cand_idx = CntW'(rd_idx_r);
  // Smaller index wins ties, so rank above means bigger key or equal key
  // with smaller index.
  assign below_prev = !have_prev_r || (rd_data < prev_key_r) ||
                      ((rd_data == prev_key_r) && (cand_idx > prev_idx_r));
  assign above_best = !best_ok_r || (rd_data > best_key_r);

  always_comb begin
    slots_clamped = (slot_cfg_r > SlotW'(MaxSlots)) ? SlotW'(MaxSlots) : slot_cfg_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_last_record && (slots_clamped != '0)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (ctl.last_rd || (k_ext >= cnt_ext)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (k_r + SlotW'(1) == slots_r) begin
          state_nxt = ST_IDLE;
        end else if (k_ext + CmpW'(1) < cnt_ext) begin
          state_nxt = ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_cfg_r  <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      scan_r      <= '0;
      rd_ok_r     <= 1'b0;
      have_prev_r <= 1'b0;
      best_ok_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        slot_cfg_r <= cfg_wdata;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_last_record) begin
              slots_r     <= slots_clamped;
              k_r         <= '0;
              have_prev_r <= 1'b0;
              scan_r      <= '0;
              best_ok_r   <= 1'b0;
              rd_ok_r     <= 1'b0;
              // With no slots the batch ends here and nothing is emitted.
              if (slots_clamped == '0) begin
                count_r <= '0;
                ovf_r   <= 1'b0;
              end else if (store_wr) begin
                count_r <= count_r + CntW'(1);
              end else begin
                ovf_r <= 1'b1;
              end
            end else if (store_wr) begin
              count_r <= count_r + CntW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        ST_READ: begin
          rd_ok_r  <= (scan_r < count_r);
          rd_idx_r <= scan_r[AddrW-1:0];
          scan_r   <= scan_r + CntW'(1);
        end
        ST_SCAN: begin
          if (rd_ok_r && below_prev && above_best) begin
            best_ok_r  <= 1'b1;
            best_key_r <= rd_data;
            best_idx_r <= cand_idx;
          end
          rd_ok_r  <= (scan_r < count_r);
          rd_idx_r <= scan_r[AddrW-1:0];
          if (scan_r < count_r) begin
            scan_r <= scan_r + CntW'(1);
          end
        end
        ST_EMIT: begin
          out_valid_r  <= 1'b1;
          out_rank_r   <= k_r + SlotW'(1);
          out_filled_r <= best_ok_r;
          out_idx_r    <= best_ok_r ? SlotW'(best_idx_r + CntW'(1)) : '0;
          out_ovf_r    <= ovf_r;
          out_last_r   <= (k_r + SlotW'(1) == slots_r);
          have_prev_r  <= best_ok_r;
          prev_key_r   <= best_key_r;
          prev_idx_r   <= best_idx_r;
          best_ok_r    <= 1'b0;
          scan_r       <= '0;
          rd_ok_r      <= 1'b0;
          k_r          <= k_r + SlotW'(1);
          if (k_r + SlotW'(1) == slots_r) begin
            count_r <= '0;
            ovf_r   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rank         = out_rank_r;
  assign out_record_index = out_idx_r;
  assign out_filled       = out_filled_r;
  assign out_overflow     = out_ovf_r;
  assign out_last_result  = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(CAPACITY))
    else $error("record count beyond capacity");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> state_r == ST_IDLE)
    else $error("last result while still busy");
  a_unfilled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_filled |-> out_record_index == '0)
    else $error("unfilled slot carries an index");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |=> out_valid)
    else $error("emit cycle without a result beat");
`endif

endmodule
